// File: rtl/ssp_pkg.sv
// Shared types and constants for the servo status packet receiver.
package ssp_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [8:0] LEN_EXTRA    = 9'd2;

    localparam logic [7:0] EXPECTED_ID_RESET = 8'd1;
    localparam logic [7:0] PARAM_COUNT_RESET = 8'd0;
    localparam logic [7:0] HUNT_LIMIT_RESET  = 8'd10;

    typedef enum logic [1:0] {
        REG_EXPECTED_ID = 2'd0,
        REG_PARAM_COUNT = 2'd1,
        REG_HUNT_LIMIT  = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_ERR   = 3'd3,
        PH_PARAM = 3'd4,
        PH_CSUM  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOHEAD  = 3'd1,
        ST_BADID   = 3'd2,
        ST_BADLEN  = 3'd3,
        ST_BADSUM  = 3'd4,
        ST_TIMEOUT = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] expected_id;
        logic [7:0] param_count;
        logic [7:0] hunt_limit;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       is_status;
        logic [7:0] data_byte;
        status_t    status_code;
        logic [7:0] servo_error;
        logic [7:0] responder_id;
    } result_t;

endpackage

// File: rtl/ssp_parser.sv
// Packet parsing state machine: consumes one word per step and forms at most one result.
module ssp_parser
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] hunt_count_reg, hunt_count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] error_reg, error_next;
    logic [7:0] id_reg, id_next;
    logic       closing;

    // Result of the current word.
    always_comb
    begin
        res             = '0;
        res.status_code = ST_OK;

        if (req_type) begin
            res.valid        = 1'b1;
            res.is_status    = 1'b1;
            res.status_code  = ST_TIMEOUT;
            res.responder_id = id_reg;
        end else begin
            unique case (phase_reg)
                PH_ID:
                begin
                    if (cfg.expected_id != BROADCAST_ID && rx_byte != cfg.expected_id) begin
                        res.valid        = 1'b1;
                        res.is_status    = 1'b1;
                        res.status_code  = ST_BADID;
                        res.responder_id = rx_byte;
                    end
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} != {1'b0, cfg.param_count} + LEN_EXTRA) begin
                        res.valid        = 1'b1;
                        res.is_status    = 1'b1;
                        res.status_code  = ST_BADLEN;
                        res.responder_id = id_reg;
                    end
                end
                PH_ERR:
                begin
                end
                PH_PARAM:
                begin
                    res.valid        = 1'b1;
                    res.data_byte    = rx_byte;
                    res.responder_id = id_reg;
                end
                PH_CSUM:
                begin
                    res.valid        = 1'b1;
                    res.is_status    = 1'b1;
                    res.responder_id = id_reg;
                    if (~sum_reg == rx_byte) begin
                        res.status_code = ST_OK;
                        res.servo_error = error_reg;
                    end else begin
                        res.status_code = ST_BADSUM;
                    end
                end
                default:
                begin
                    // Header hunt; unused phase codes land here as well.
                    if (!(prev_reg == HEADER_BYTE && rx_byte == HEADER_BYTE) &&
                        hunt_count_reg >= cfg.hunt_limit) begin
                        res.valid        = 1'b1;
                        res.is_status    = 1'b1;
                        res.status_code  = ST_NOHEAD;
                        res.responder_id = id_reg;
                    end
                end
            endcase
        end
    end

    // Every status result ends the packet and restarts the hunt from clean state.
    assign closing = res.valid && res.is_status;

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        hunt_count_next = hunt_count_reg;
        sum_next        = sum_reg;
        left_next       = left_reg;
        error_next      = error_reg;
        id_next         = id_reg;

        if (closing) begin
            phase_next      = PH_HUNT;
            prev_next       = 8'd0;
            hunt_count_next = 8'd0;
            sum_next        = 8'd0;
            left_next       = 8'd0;
            error_next      = 8'd0;
            id_next         = 8'd0;
        end else if (!req_type) begin
            unique case (phase_reg)
                PH_ID:
                begin
                    id_next    = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    sum_next   = sum_reg + rx_byte;
                    left_next  = cfg.param_count;
                    phase_next = PH_ERR;
                end
                PH_ERR:
                begin
                    error_next = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (left_reg == 8'd0) ? PH_CSUM : PH_PARAM;
                end
                PH_PARAM:
                begin
                    sum_next  = sum_reg + rx_byte;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                end
                default:
                begin
                    if (prev_reg == HEADER_BYTE && rx_byte == HEADER_BYTE) begin
                        prev_next       = 8'd0;
                        hunt_count_next = 8'd0;
                        phase_next      = PH_ID;
                    end else begin
                        prev_next       = rx_byte;
                        hunt_count_next = hunt_count_reg + 8'd1;
                        phase_next      = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_HUNT;
            prev_reg       <= 8'd0;
            hunt_count_reg <= 8'd0;
            sum_reg        <= 8'd0;
            left_reg       <= 8'd0;
            error_reg      <= 8'd0;
            id_reg         <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            prev_reg       <= prev_next;
            hunt_count_reg <= hunt_count_next;
            sum_reg        <= sum_next;
            left_reg       <= left_next;
            error_reg      <= error_next;
            id_reg         <= id_next;
        end
    end

endmodule

// File: rtl/ssp_out_reg.sv
// Result register that holds one finished word until the consumer takes it.
module ssp_out_reg
    import ssp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t held
);

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

// File: rtl/servo_status_packet_receiver.sv
// Top level of the servo status packet receiver: input register, configuration and wiring.
//
// The receiver takes one word per cycle while its output is not held up: a received servo
// byte or a receive timeout. A word passes through an input register, the parsing state
// machine then handles it and any result lands in an output register, so the sustained rate
// is one word per clock while out_ready is high; results are presented from the output
// register. The input register keeps accepting while a finished result waits there; only
// when both are full does in_ready fall. The parser hunts for the 0xFF 0xFF header and gives
// up with status "no header" after hunt_limit+1 bytes that do not complete one. It checks
// the ID byte against expected_id (0xFE accepts any ID), requires a length of param_count+2,
// forwards each parameter byte as a data word (is_status low), and ends every packet,
// failure or timeout with exactly one status word. Status codes are 0 ok, 1 no header,
// 2 wrong id, 3 wrong length, 4 bad checksum and 5 timeout. The configuration registers are
// written through cfg_we, cfg_index and cfg_data and should only change while the block is
// idle.
module servo_status_packet_receiver
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_status,
    output logic [7:0] data_byte,
    output logic [2:0] status_code,
    output logic [7:0] servo_error,
    output logic [7:0] responder_id
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic       req_reg;
    logic [7:0] byte_reg;
    logic       step;
    result_t    res;
    result_t    held;

    // Configuration registers; a write to an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.expected_id <= EXPECTED_ID_RESET;
            cfg_reg.param_count <= PARAM_COUNT_RESET;
            cfg_reg.hunt_limit  <= HUNT_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EXPECTED_ID: cfg_reg.expected_id <= cfg_data;
                REG_PARAM_COUNT: cfg_reg.param_count <= cfg_data;
                REG_HUNT_LIMIT:  cfg_reg.hunt_limit  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The parser advances whenever a word is waiting and the output register can take a result.
    assign step     = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            req_reg  <= req_type;
            byte_reg <= rx_byte;
        end
    end

    ssp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req_type (req_reg),
        .rx_byte  (byte_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    ssp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res.valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .held      (held)
    );

    assign is_status    = held.is_status;
    assign data_byte    = held.data_byte;
    assign status_code  = held.status_code;
    assign servo_error  = held.servo_error;
    assign responder_id = held.responder_id;

    // A result formed by a step must be presented in the next cycle.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid |=> out_valid)
        else $error("result of a parser step was not loaded into the output register");

    // The parser must not advance while a result is stalled in the output register.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !step)
        else $error("parser advanced while the output register was blocked");

    // A data word carries no status and no servo error.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> status_code == ST_OK && servo_error == 8'd0)
        else $error("data word carries status fields");

endmodule
